/* hw/rtl/tkfv_pkg.sv */
// ----------------------------------------------------------------------------
// tkfv_pkg
// Shared types and constants for the top-k frequent values core.
// ----------------------------------------------------------------------------
package tkfv_pkg;

  localparam int unsigned TableSize = 1024;
  localparam int unsigned MaxTop    = 64;
  localparam int unsigned SlotW     = $clog2(TableSize);
  localparam int unsigned HeapW     = $clog2(MaxTop);

  typedef struct packed {
    logic [31:0] sample_value;
    logic        is_final;
  } tkfv_in_t;

  typedef struct packed {
    logic [31:0] frequent_value;
    logic [15:0] value_count;
    logic        final_result;
    logic        table_overflow;
  } tkfv_out_t;

  typedef struct packed {
    logic [31:0]   key;
    logic [15:0]   count;
  } tkfv_entry_t;

  // Home slot: multiplicative hash folded with itself shifted right by 15.
  function automatic logic [SlotW-1:0] home_slot(input logic [31:0] v);
    logic [31:0] h;
    h = v * 32'd2654435761;
    h = h ^ (h >> 15);
    return h[SlotW-1:0];
  endfunction

endpackage

/* hw/rtl/tkfv_heap.sv */
// ----------------------------------------------------------------------------
// tkfv_heap
// Min-heap of (value, count) pairs held in a synchronous memory, with push,
// replace-root and pop operations sequenced one memory access per cycle.
// ----------------------------------------------------------------------------
module tkfv_heap (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        repl_i,
  input  logic                        pop_i,
  input  tkfv_pkg::tkfv_entry_t       ent_i,
  output logic                        busy_o,
  output logic [tkfv_pkg::HeapW:0]    fill_o,
  output tkfv_pkg::tkfv_entry_t       root_o
);
  import tkfv_pkg::*;

  typedef enum logic [6:0] {
    H_IDLE  = 7'b0000001,
    H_UPRD  = 7'b0000010,
    H_UPCMP = 7'b0000100,
    H_LAST  = 7'b0001000,
    H_DNL   = 7'b0010000,
    H_DNR   = 7'b0100000,
    H_DNCMP = 7'b1000000
  } h_state_e;

  h_state_e state_q, state_d;
  tkfv_entry_t mem [MaxTop];
  tkfv_entry_t rd_q;
  logic [HeapW-1:0] raddr;
  logic             we;
  logic [HeapW-1:0] waddr;
  tkfv_entry_t      wdata;

  logic [HeapW:0]   fill_q, fill_d;
  logic [HeapW-1:0] idx_q, idx_d;
  tkfv_entry_t      cur_q, cur_d;     // element being sifted
  tkfv_entry_t      lft_q, lft_d;     // left child during sift-down
  tkfv_entry_t      nxt_q, nxt_d;     // entry pushed after a replace
  logic             pend_q, pend_d;
  tkfv_entry_t      top_q;
  tkfv_entry_t      ch;
  logic             sel_r;
  logic             dn_done;
  logic [HeapW:0]   lidx, ridx;
  logic [HeapW-1:0] par;

  assign par   = (idx_q - 1'b1) >> 1;
  assign lidx  = {idx_q, 1'b1};
  assign ridx  = lidx + 1'b1;
  assign sel_r = (ridx < fill_q) && (rd_q.count < lft_q.count);
  assign ch    = sel_r ? rd_q : lft_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // The sifted element stays in cur_q and is written once its place is found.
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    lft_d   = lft_q;
    nxt_d   = nxt_q;
    pend_d  = pend_q;
    raddr   = '0;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = cur_q;
    dn_done = 1'b0;
    case (state_q)
      H_IDLE: begin
        if (push_i) begin
          cur_d   = ent_i;
          idx_d   = fill_q[HeapW-1:0];
          fill_d  = fill_q + 1'b1;
          state_d = H_UPRD;
        end else if (repl_i || pop_i) begin
          // A replace is a full pop followed by a push of the new entry.
          raddr   = fill_q[HeapW-1:0] - 1'b1;
          fill_d  = fill_q - 1'b1;
          nxt_d   = ent_i;
          pend_d  = repl_i;
          state_d = H_LAST;
        end
      end
      H_UPRD: begin
        if (idx_q == '0) begin
          we = 1'b1; waddr = '0; wdata = cur_q;
          state_d = H_IDLE;
        end else begin
          raddr   = par;
          state_d = H_UPCMP;
        end
      end
      H_UPCMP: begin
        we = 1'b1;
        if (rd_q.count < cur_q.count) begin
          wdata   = cur_q;
          state_d = H_IDLE;
        end else begin
          wdata   = rd_q;
          idx_d   = par;
          state_d = H_UPRD;
        end
      end
      H_LAST: begin
        // rd_q holds the old last element, which sifts down from the root.
        cur_d   = rd_q;
        idx_d   = '0;
        state_d = H_DNL;
      end
      H_DNL: begin
        if (lidx >= fill_q) begin
          we      = 1'b1;
          dn_done = 1'b1;
        end else begin
          raddr   = lidx[HeapW-1:0];
          state_d = H_DNR;
        end
      end
      H_DNR: begin
        lft_d   = rd_q;
        raddr   = ridx[HeapW-1:0];
        state_d = H_DNCMP;
      end
      H_DNCMP: begin
        we = 1'b1;
        if (cur_q.count < ch.count) begin
          dn_done = 1'b1;
        end else begin
          wdata   = ch;
          idx_d   = sel_r ? ridx[HeapW-1:0] : lidx[HeapW-1:0];
          state_d = H_DNL;
        end
      end
      default: state_d = H_IDLE;
    endcase
    if (dn_done) begin
      if (pend_q) begin
        cur_d   = nxt_q;
        idx_d   = fill_q[HeapW-1:0];
        fill_d  = fill_q + 1'b1;
        pend_d  = 1'b0;
        state_d = H_UPRD;
      end else begin
        state_d = H_IDLE;
      end
    end
  end

  // Root cache: entry 0 as seen after the last write to it.
  always_ff @(posedge clk_i) begin
    if (we && waddr == '0) top_q <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      fill_q  <= '0;
      idx_q   <= '0;
      cur_q   <= '0;
      lft_q   <= '0;
      nxt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      cur_q   <= cur_d;
      lft_q   <= lft_d;
      nxt_q   <= nxt_d;
      pend_q  <= pend_d;
    end
  end

  assign busy_o = (state_q != H_IDLE);
  assign fill_o = fill_q;
  assign root_o = top_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= MaxTop)
    else $error("heap fill exceeds capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !busy_o) |=> (fill_q == $past(fill_q) + 1'b1))
    else $error("push did not grow heap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pop_i || repl_i) && !busy_o) |-> (fill_q != '0))
    else $error("pop from empty heap");

endmodule

/* hw/rtl/top_k_frequent_values_core.sv */
// ----------------------------------------------------------------------------
// top_k_frequent_values_core
// Counts values in a hashed table, then reports the k most frequent ones.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake
// input   | in        | start, busy
// result  | out       | result_valid_o strobe, one cycle
// config  | in        | cfg_we_i, cfg_wdata_i
// After an item is accepted, the table is read and then compared and written
// before the next item can be accepted; each extra probe step repeats both.
// After the final item the table is swept (1024 slots, each read and cleared,
// plus heap sifting) and results follow, each followed by one heap pop.
// The sweep also clears valid bits, so the next list starts clean.
// After reset a clearing pass over all 1024 slots runs with busy high.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module top_k_frequent_values_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tkfv_pkg::tkfv_in_t   in_i,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i,
  output logic                 result_valid_o,
  output tkfv_pkg::tkfv_out_t  result_o
);
  import tkfv_pkg::*;

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_RD   = 10'b0000000100,
    S_CHK  = 10'b0000001000,
    S_SRD  = 10'b0000010000,
    S_SCHK = 10'b0000100000,
    S_HWT  = 10'b0001000000,
    S_OUT  = 10'b0010000000,
    S_PWT  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [6:0] k_q;
  logic [31:0] key_q;
  logic        fin_q;
  logic [SlotW-1:0] pos_q, pos_d;
  logic [SlotW:0]   probe_q, probe_d;
  logic             ovf_q, ovf_d;

  // Slot memory: valid, key, count per entry.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [15:0] count;
  } slot_t;
  slot_t tab [TableSize];
  slot_t rd_q, wdata;
  logic  we;
  logic [SlotW-1:0] raddr, waddr;

  always_ff @(posedge clk_i) begin
    if (we) tab[waddr] <= wdata;
    rd_q <= tab[raddr];
  end

  logic        h_push, h_repl, h_pop, h_busy;
  logic [HeapW:0] h_fill;
  tkfv_entry_t h_root, h_ent;
  logic [6:0]  k_eff;

  assign k_eff = (k_q == '0) ? 7'd1 : ((k_q > MaxTop) ? 7'(MaxTop) : k_q);

  tkfv_heap u_heap (
    .clk_i, .rst_ni,
    .push_i(h_push), .repl_i(h_repl), .pop_i(h_pop),
    .ent_i(h_ent), .busy_o(h_busy), .fill_o(h_fill), .root_o(h_root)
  );

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    probe_d = probe_q;
    ovf_d   = ovf_q;
    raddr   = pos_q;
    waddr   = pos_q;
    we      = 1'b0;
    wdata   = '0;
    h_push  = 1'b0;
    h_repl  = 1'b0;
    h_pop   = 1'b0;
    h_ent   = '{key: rd_q.key, count: rd_q.count};
    result_valid_o = 1'b0;
    case (state_q)
      S_CLR: begin
        we = 1'b1;
        pos_d = pos_q + 1'b1;
        if (pos_q == SlotW'(TableSize - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          pos_d   = home_slot(in_i.sample_value);
          probe_d = '0;
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        if (!rd_q.valid) begin
          we = 1'b1; wdata = '{valid: 1'b1, key: key_q, count: 16'd1};
          state_d = fin_q ? S_SRD : S_IDLE;
          pos_d   = fin_q ? '0 : pos_q;
        end else if (rd_q.key == key_q) begin
          we = 1'b1;
          wdata = '{valid: 1'b1, key: key_q,
                    count: (rd_q.count == 16'hFFFF) ? rd_q.count : rd_q.count + 1'b1};
          state_d = fin_q ? S_SRD : S_IDLE;
          pos_d   = fin_q ? '0 : pos_q;
        end else if (probe_q == (SlotW+1)'(TableSize - 1)) begin
          ovf_d   = 1'b1;
          state_d = fin_q ? S_SRD : S_IDLE;
          pos_d   = fin_q ? '0 : pos_q;
        end else begin
          pos_d   = pos_q + 1'b1;
          probe_d = probe_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_SRD: state_d = S_SCHK;
      S_SCHK: begin
        // Clear the slot while scanning it.
        we = 1'b1; wdata = '0;
        if (rd_q.valid) begin
          if (h_fill == k_eff[HeapW:0]) begin
            if (h_root.count < rd_q.count) h_repl = 1'b1;
          end else begin
            h_push = 1'b1;
          end
        end
        state_d = S_HWT;
      end
      S_HWT: begin
        if (!h_busy) begin
          if (pos_q == SlotW'(TableSize - 1)) begin
            state_d = (h_fill == '0) ? S_DONE : S_OUT;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = S_SRD;
          end
        end
      end
      S_OUT: begin
        result_valid_o = 1'b1;
        h_pop   = 1'b1;
        state_d = S_PWT;
      end
      S_PWT: begin
        if (!h_busy) state_d = (h_fill == '0) ? S_DONE : S_OUT;
      end
      S_DONE: begin
        ovf_d   = 1'b0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign result_o = '{frequent_value: h_root.key, value_count: h_root.count,
                      final_result: (h_fill == {{HeapW{1'b0}}, 1'b1}),
                      table_overflow: ovf_q};
  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      key_q <= in_i.sample_value;
      fin_q <= in_i.is_final;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      pos_q   <= '0;
      probe_q <= '0;
      ovf_q   <= 1'b0;
      k_q     <= 7'd1;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      probe_q <= probe_d;
      ovf_q   <= ovf_d;
      if (cfg_we_i) k_q <= cfg_wdata_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> h_fill != '0) else $error("result from empty heap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_fill <= k_eff[HeapW:0] || state_q == S_CLR) else $error("heap above k");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back-to-back results");

endmodule

/* bench/top_k_frequent_values_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_frequent_values_checker
// Watches the input, config and result channels of the top-k core, keeps its
// own count table and heap, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module top_k_frequent_values_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  tkfv_pkg::tkfv_in_t  in_i,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic                result_valid_i,
  input  tkfv_pkg::tkfv_out_t result_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import tkfv_pkg::*;

  logic        used_q [TableSize];
  logic [31:0] key_q  [TableSize];
  logic [15:0] cnt_q  [TableSize];
  logic [31:0] hval   [MaxTop];
  logic [15:0] hfreq  [MaxTop];
  int          hfill;
  logic        ovf_q;
  logic [6:0]  k_reg;
  tkfv_out_t   expected_results [$];

  function automatic int unsigned hash_slot(logic [31:0] v);
    logic [31:0] h;
    h = v * 32'd2654435761;
    h = h ^ (h >> 15);
    return h % TableSize;
  endfunction

  function automatic void tally(logic [31:0] v);
    int unsigned p;
    p = hash_slot(v);
    for (int n = 0; n < TableSize; n++) begin
      if (!used_q[p]) begin
        used_q[p] = 1'b1; key_q[p] = v; cnt_q[p] = 16'd1;
        return;
      end
      if (key_q[p] == v) begin
        if (cnt_q[p] != 16'hFFFF) cnt_q[p]++;
        return;
      end
      p = (p + 1) % TableSize;
    end
    ovf_q = 1'b1;
  endfunction

  function automatic void hswap(int i, int j);
    logic [31:0] v;
    logic [15:0] f;
    v = hval[i]; f = hfreq[i];
    hval[i] = hval[j]; hfreq[i] = hfreq[j];
    hval[j] = v; hfreq[j] = f;
  endfunction

  function automatic void hpush(logic [31:0] v, logic [15:0] f);
    int i;
    int par;
    i = hfill++;
    hval[i] = v; hfreq[i] = f;
    while (i > 0) begin
      par = (i - 1) / 2;
      if (hfreq[par] < hfreq[i]) return;
      hswap(par, i);
      i = par;
    end
  endfunction

  function automatic void hpop();
    int i;
    int l;
    int s;
    i = 0;
    hfill--;
    hval[0] = hval[hfill]; hfreq[0] = hfreq[hfill];
    forever begin
      l = 2 * i + 1;
      if (l >= hfill) return;
      s = l;
      if (l + 1 < hfill && hfreq[l + 1] < hfreq[l]) s = l + 1;
      if (hfreq[i] < hfreq[s]) return;
      hswap(i, s);
      i = s;
    end
  endfunction

  function automatic void clear_list();
    for (int p = 0; p < TableSize; p++) used_q[p] = 1'b0;
    hfill = 0;
    ovf_q = 1'b0;
  endfunction

  function automatic void report_top_values();
    int k;
    int n;
    tkfv_out_t r;
    k = (k_reg == 0) ? 1 : ((k_reg > MaxTop) ? MaxTop : k_reg);
    for (int p = 0; p < TableSize; p++) begin
      if (!used_q[p]) continue;
      if (hfill == k) begin
        if (hfreq[0] < cnt_q[p]) begin
          hpop();
          hpush(key_q[p], cnt_q[p]);
        end
      end else begin
        hpush(key_q[p], cnt_q[p]);
      end
    end
    n = hfill;
    for (int i = 0; i < n; i++) begin
      r.frequent_value = hval[0];
      r.value_count    = hfreq[0];
      r.final_result   = (i + 1 == n);
      r.table_overflow = ovf_q;
      expected_results.push_back(r);
      hpop();
    end
    clear_list();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tkfv_out_t e;
    if (!rst_ni) begin
      clear_list();
      k_reg <= 7'd1;
      fail_count_o <= 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_results.pop_front();
          if (e !== result_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, result_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) k_reg <= cfg_wdata_i;
      if (start_i && !busy_i) begin
        tally(in_i.sample_value);
        if (in_i.is_final) report_top_values();
      end
      pending_o <= expected_results.size();
    end
  end
endmodule

/* bench/top_k_frequent_values_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_frequent_values_core_tb
// Drives lists of values with random gaps and several top-count settings into
// the top-k core; the checker predicts and compares the reported values.
// ----------------------------------------------------------------------------
module top_k_frequent_values_core_tb;
  import tkfv_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  tkfv_in_t  in_i;
  logic      cfg_we_i;
  logic [6:0] cfg_wdata_i;
  logic      result_valid_o;
  tkfv_out_t result_o;
  int        fail_count;
  int        pending;
  logic [31:0] pool [16];

  top_k_frequent_values_core u_dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .cfg_we_i, .cfg_wdata_i,
    .result_valid_o, .result_o
  );

  top_k_frequent_values_checker u_chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .in_i, .cfg_we_i,
    .cfg_wdata_i, .result_valid_i(result_valid_o), .result_i(result_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(negedge clk_i);
  endtask

  // One transaction: hold start until the block takes it. Busy is stable at
  // the falling edge, so a low busy there means the next rising edge accepts.
  task automatic send_value(logic [31:0] v, logic fin);
    start = 1'b1;
    in_i.sample_value = v;
    in_i.is_final = fin;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    start = 1'b0;
    idle_gap();
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    // The last pop still runs after the last result.
    while (busy) @(negedge clk_i);
  endtask

  task automatic set_top(logic [6:0] k);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = k;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_list(int len, int spread);
    logic [31:0] v;
    for (int i = 0; i < len; i++) begin
      v = (spread == 0) ? $urandom : pool[$urandom_range(0, spread - 1)];
      send_value(v, i == len - 1);
    end
  endtask

  initial begin
    logic [6:0] ks [6];
    ks = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd3};
    start = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, ties, a single-element list, then k=4 on few values.
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h7FFF_FFFF, 1'b0);
    send_value(32'h7FFF_FFFF, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'h0000_0000, 1'b1);
    send_value(32'h1234_5678, 1'b1);
    set_top(7'd4);
    send_value(32'd7, 1'b0);
    send_value(32'd7, 1'b0);
    send_value(32'd9, 1'b0);
    send_value(32'hAAAA_5555, 1'b0);
    send_value(32'h5555_AAAA, 1'b1);
    send_value(32'd3, 1'b0);
    send_value(32'd3, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_top(ks[ph]);
      for (int j = 0; j < 16; j++) pool[j] = $urandom;
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7FFF_FFFF;
      random_list($urandom_range(30, 50), $urandom_range(2, 16));
      random_list($urandom_range(10, 20), 0);
      if (ph == 2) drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* top_k_frequent_values_core.f */
hw/rtl/tkfv_pkg.sv
hw/rtl/tkfv_heap.sv
hw/rtl/top_k_frequent_values_core.sv
bench/top_k_frequent_values_checker.sv
bench/top_k_frequent_values_core_tb.sv
